// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only out of reset
`define BRD_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked during reset as well
`define BRD_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/brd_pkg.sv -----
// types and constants of the bus region decoder
package brd_pkg;

    localparam int IO_IDX_W = 9;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_RAISE = 2'd2;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    localparam logic [3:0] TGT_NONE      = 4'd0;
    localparam logic [3:0] TGT_WRAM_BIG  = 4'd1;
    localparam logic [3:0] TGT_WRAM_FAST = 4'd2;
    localparam logic [3:0] TGT_PALETTE   = 4'd3;
    localparam logic [3:0] TGT_VIDEO     = 4'd4;
    localparam logic [3:0] TGT_SPRITE    = 4'd5;
    localparam logic [3:0] TGT_CART      = 4'd6;
    localparam logic [3:0] TGT_SAVE      = 4'd7;
    localparam logic [3:0] TGT_IO_VIDEO  = 4'd8;
    localparam logic [3:0] TGT_IO_DMA    = 4'd9;
    localparam logic [3:0] TGT_IO_TIMER  = 4'd10;
    localparam logic [3:0] TGT_IO_SOUND  = 4'd11;
    localparam logic [3:0] TGT_SND_BYTE  = 4'd12;
    localparam logic [3:0] TGT_FIFO_WORD = 4'd13;
    localparam logic [3:0] TGT_INTERNAL  = 4'd14;

    localparam logic [3:0] REG_WRAM_BIG  = 4'h2;
    localparam logic [3:0] REG_WRAM_FAST = 4'h3;
    localparam logic [3:0] REG_IO        = 4'h4;
    localparam logic [3:0] REG_PALETTE   = 4'h5;
    localparam logic [3:0] REG_VIDEO     = 4'h6;
    localparam logic [3:0] REG_SPRITE    = 4'h7;
    localparam logic [3:0] REG_CART_0    = 4'h8;
    localparam logic [3:0] REG_CART_1    = 4'h9;
    localparam logic [3:0] REG_CART_2    = 4'hA;
    localparam logic [3:0] REG_CART_3    = 4'hB;
    localparam logic [3:0] REG_CART_4    = 4'hC;
    localparam logic [3:0] REG_CART_5    = 4'hD;
    localparam logic [3:0] REG_SAVE_0    = 4'hE;
    localparam logic [3:0] REG_SAVE_1    = 4'hF;

    localparam logic [21:0] IO_PAGE      = 22'h010000;
    localparam logic [9:0]  OFF_VID_END  = 10'h040;
    localparam logic [9:0]  OFF_SND_LO   = 10'h060;
    localparam logic [9:0]  OFF_FIFO_LO  = 10'h0A0;
    localparam logic [9:0]  OFF_DMA_LO   = 10'h0B0;
    localparam logic [9:0]  OFF_DMA_END  = 10'h0E0;
    localparam logic [9:0]  OFF_TMR_LO   = 10'h100;
    localparam logic [9:0]  OFF_TMR_END  = 10'h110;
    localparam logic [9:0]  OFF_KEYS     = 10'h130;
    localparam logic [9:0]  OFF_IE       = 10'h200;
    localparam logic [9:0]  OFF_IF       = 10'h202;
    localparam logic [9:0]  OFF_WAITCNT  = 10'h204;
    localparam logic [9:0]  OFF_IME      = 10'h208;
    localparam logic [16:0] VRAM_MIRROR  = 17'h18000;
    localparam logic [16:0] VRAM_FOLD    = 17'h08000;
    localparam logic [11:0] SAVE_BASE    = 12'hE00;
    localparam logic [9:0]  KEYS_IDLE    = 10'h3FF;

    typedef enum logic [2:0] {
        PK_BYTE,
        PK_IO,
        PK_FIFO,
        PK_RAISE,
        PK_NOP
    } t_piece_kind;

    typedef struct packed {
        logic        valid;
        t_piece_kind kind;
        logic        is_store;
        logic [31:0] addr;
        logic [31:0] data;
        logic [9:0]  keys;
        logic        last;
    } t_piece;

    typedef struct packed {
        logic [3:0]  target;
        logic [27:0] offset;
        logic [1:0]  piece_size;
        logic        is_store;
        logic [31:0] store_data;
        logic [15:0] read_value;
        logic        fifo_select;
        logic        last_piece;
    } t_result;

    typedef struct packed {
        logic                set_ie;
        logic                clr_if;
        logic                raise_if;
        logic                set_wc;
        logic                set_ime;
        logic                mem_wr;
        logic                mem_rd;
        logic [15:0]         value;
        logic [IO_IDX_W-1:0] idx;
    } t_reg_op;

    function automatic logic in_io_page(input logic [31:0] a);
        return a[31:10] == IO_PAGE;
    endfunction

endpackage

// ----- rtl/bus_region_decode_irq_regs.sv -----
// top level of the bus region decoder with interrupt and io registers
//
// s_axis carries one cpu bus access per item: read, write or interrupt raise
// with size, address, write data and the live button bits. m_axis carries the
// decoded pieces of each access, tlast marking the final piece of an access.
// A byte access gives one piece, a halfword one or two, a word one to four;
// raise and unused commands give none, and a raise only sets flag bits.
// Pieces leave the piece sequencer one per cycle while m_axis is not stalled;
// a new access is taken in the cycle its last piece leaves the sequencer.
// Each piece is decoded from the input register and held in the output register.
// The input register and the output register are separate stages, so the
// next access is loaded while a finished piece still waits on m_axis.
// When m_axis_tready is low on a valid piece the output register holds, and a
// result piece stalls with its register update and keeps s_axis_tready low.
// After reset the interrupt, wait and master enable registers are zero and the
// fallback io store is cleared, one entry per cycle, with s_axis_tready low.
// Reads of internal registers are answered here in read_value; fallback
// store reads come from a ram with a registered read port.
module bus_region_decode_irq_regs #(
    parameter int IO_HALFWORDS = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command, access_size, address, write_data, buttons, zero fill
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // target, offset, piece_size, is_store, store_data, read_value,
    // fifo_select, zero fill
    output logic [87:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    brd_pkg::t_piece  piece;
    brd_pkg::t_result result;
    brd_pkg::t_reg_op reg_op;

    logic [15:0] irq_enable;
    logic [15:0] irq_flags;
    logic [15:0] wait_control;
    logic        master_enable;
    logic [15:0] store_q;
    logic        busy;
    logic        has_result;
    logic        out_free;
    logic        advance;

    brd_pkg::t_result r_result;
    logic             r_out_valid;
    logic             r_from_store;
    logic [15:0]      out_read_value;

    assign has_result = piece.kind != brd_pkg::PK_RAISE && piece.kind != brd_pkg::PK_NOP;
    assign out_free   = !r_out_valid || m_axis_tready;
    assign advance    = piece.valid && (!has_result || out_free);

    brd_piece_gen u_gen (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_busy        (busy),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_command     (s_axis_tdata[1:0]),
        .i_access_size (s_axis_tdata[3:2]),
        .i_address     (s_axis_tdata[35:4]),
        .i_write_data  (s_axis_tdata[67:36]),
        .i_buttons     (s_axis_tdata[77:68]),
        .i_advance     (advance),
        .o_piece       (piece)
    );

    brd_decode #(
        .IO_HALFWORDS (IO_HALFWORDS)
    ) u_decode (
        .i_piece         (piece),
        .i_irq_enable    (irq_enable),
        .i_irq_flags     (irq_flags),
        .i_wait_control  (wait_control),
        .i_master_enable (master_enable),
        .o_result        (result),
        .o_reg_op        (reg_op)
    );

    brd_regs #(
        .IO_HALFWORDS (IO_HALFWORDS)
    ) u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (advance),
        .i_op            (reg_op),
        .o_irq_enable    (irq_enable),
        .o_irq_flags     (irq_flags),
        .o_wait_control  (wait_control),
        .o_master_enable (master_enable),
        .o_store_data    (store_q),
        .o_busy          (busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && has_result) begin
            r_result     <= result;
            r_from_store <= reg_op.mem_rd;
        end
    end

    assign out_read_value = r_from_store ? store_q : r_result.read_value;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_result.last_piece;
    assign m_axis_tdata  = {4'd0, r_result.fifo_select, out_read_value, r_result.store_data,
                            r_result.is_store, r_result.piece_size, r_result.offset,
                            r_result.target};

endmodule

// ----- rtl/brd_ram.sv -----
// generic single write port ram with registered read
module brd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/brd_piece_gen.sv -----
// input register and piece sequencer splitting an access into pieces
module brd_piece_gen (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_busy,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [1:0]      i_command,
    input  logic [1:0]      i_access_size,
    input  logic [31:0]     i_address,
    input  logic [31:0]     i_write_data,
    input  logic [9:0]      i_buttons,
    input  logic            i_advance,
    output brd_pkg::t_piece o_piece
);

    logic        r_valid;
    logic [1:0]  r_cmd;
    logic [1:0]  r_size;
    logic [31:0] r_addr;
    logic [31:0] r_data;
    logic [9:0]  r_keys;
    logic        r_half;
    logic        r_byte;

    logic        accept;
    logic        st;
    logic        wide;
    logic        use_hi;
    logic        half_last;
    logic [9:0]  off;
    logic [31:0] half_base;
    logic [15:0] half_data;

    always_comb begin
        st        = r_cmd == brd_pkg::CMD_WRITE;
        wide      = r_size != brd_pkg::SIZE_HALF;
        use_hi    = wide && r_half;
        off       = r_addr[9:0];
        half_base = use_hi ? (r_addr + 32'd2) : r_addr;
        half_base[0] = 1'b0;
        half_data = use_hi ? r_data[31:16] : r_data[15:0];
        half_last = 1'b0;

        o_piece          = '0;
        o_piece.valid    = r_valid;
        o_piece.is_store = st;
        o_piece.keys     = r_keys;
        o_piece.kind     = brd_pkg::PK_NOP;
        o_piece.last     = 1'b1;

        if (r_cmd == brd_pkg::CMD_RAISE) begin
            o_piece.kind = brd_pkg::PK_RAISE;
            o_piece.data = r_data;
        end else if (r_cmd != brd_pkg::CMD_READ && !st) begin
            o_piece.kind = brd_pkg::PK_NOP;
        end else if (r_size == brd_pkg::SIZE_BYTE) begin
            o_piece.kind = brd_pkg::PK_BYTE;
            o_piece.addr = r_addr;
            o_piece.data = {24'd0, r_data[7:0]};
        end else if (wide && st && r_addr[1:0] == 2'b00 && brd_pkg::in_io_page(r_addr)
                     && off >= brd_pkg::OFF_FIFO_LO && off < brd_pkg::OFF_DMA_LO) begin
            o_piece.kind = brd_pkg::PK_FIFO;
            o_piece.addr = r_addr;
            o_piece.data = r_data;
        end else begin
            if (brd_pkg::in_io_page(half_base)) begin
                o_piece.kind = brd_pkg::PK_IO;
                o_piece.addr = half_base;
                o_piece.data = {16'd0, half_data};
                half_last    = 1'b1;
            end else begin
                o_piece.kind = brd_pkg::PK_BYTE;
                o_piece.addr = {half_base[31:1], r_byte};
                o_piece.data = {24'd0, r_byte ? half_data[15:8] : half_data[7:0]};
                half_last    = r_byte;
            end
            o_piece.last = half_last && (!wide || r_half);
        end
    end

    assign o_ready = !i_busy && (!r_valid || (i_advance && o_piece.last));
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
            r_byte  <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
            r_half  <= 1'b0;
            r_byte  <= 1'b0;
        end else if (i_advance) begin
            if (o_piece.last) begin
                r_valid <= 1'b0;
            end else if (half_last) begin
                r_half <= 1'b1;
                r_byte <= 1'b0;
            end else begin
                r_byte <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_command;
            r_size <= i_access_size;
            r_addr <= i_address;
            r_data <= i_write_data;
            r_keys <= i_buttons;
        end
    end

endmodule

// ----- rtl/brd_decode.sv -----
// region decode of one piece and the register operation it causes
module brd_decode #(
    parameter int IO_HALFWORDS = 512
) (
    input  brd_pkg::t_piece  i_piece,
    input  logic [15:0]      i_irq_enable,
    input  logic [15:0]      i_irq_flags,
    input  logic [15:0]      i_wait_control,
    input  logic             i_master_enable,
    output brd_pkg::t_result o_result,
    output brd_pkg::t_reg_op o_reg_op
);

    localparam logic [brd_pkg::IO_IDX_W:0] DEPTH_L = (brd_pkg::IO_IDX_W + 1)'(IO_HALFWORDS);

    logic [27:0] a;
    logic [9:0]  off;
    logic [16:0] voff;
    logic        st;
    logic        in_store;
    logic [15:0] rv;

    always_comb begin
        a        = i_piece.addr[27:0];
        off      = i_piece.addr[9:0];
        st       = i_piece.is_store;
        in_store = {1'b0, off[9:1]} < DEPTH_L;
        voff     = a[16:0];
        if (voff >= brd_pkg::VRAM_MIRROR) begin
            voff = voff - brd_pkg::VRAM_FOLD;
        end
        rv = '0;

        o_result            = '0;
        o_result.is_store   = st;
        o_result.last_piece = i_piece.last;
        o_reg_op            = '0;
        o_reg_op.value      = i_piece.data[15:0];
        o_reg_op.idx        = off[9:1];

        unique case (i_piece.kind)
            brd_pkg::PK_BYTE: begin
                o_result.piece_size = brd_pkg::SIZE_BYTE;
                case (a[27:24])
                    brd_pkg::REG_WRAM_BIG: begin
                        o_result.target = brd_pkg::TGT_WRAM_BIG;
                        o_result.offset = {10'd0, a[17:0]};
                    end
                    brd_pkg::REG_WRAM_FAST: begin
                        o_result.target = brd_pkg::TGT_WRAM_FAST;
                        o_result.offset = {13'd0, a[14:0]};
                    end
                    brd_pkg::REG_IO: begin
                        if (st && off >= brd_pkg::OFF_SND_LO && off < brd_pkg::OFF_DMA_LO) begin
                            o_result.target = brd_pkg::TGT_SND_BYTE;
                            o_result.offset = {18'd0, off};
                        end
                    end
                    brd_pkg::REG_PALETTE: begin
                        o_result.target = brd_pkg::TGT_PALETTE;
                        o_result.offset = {18'd0, off};
                    end
                    brd_pkg::REG_VIDEO: begin
                        o_result.target = brd_pkg::TGT_VIDEO;
                        o_result.offset = {11'd0, voff};
                    end
                    brd_pkg::REG_SPRITE: begin
                        o_result.target = brd_pkg::TGT_SPRITE;
                        o_result.offset = {18'd0, off};
                    end
                    brd_pkg::REG_CART_0, brd_pkg::REG_CART_1, brd_pkg::REG_CART_2,
                    brd_pkg::REG_CART_3, brd_pkg::REG_CART_4, brd_pkg::REG_CART_5: begin
                        if (!st) begin
                            o_result.target = brd_pkg::TGT_CART;
                            o_result.offset = a;
                        end
                    end
                    brd_pkg::REG_SAVE_0, brd_pkg::REG_SAVE_1: begin
                        o_result.target = brd_pkg::TGT_SAVE;
                        o_result.offset = {brd_pkg::SAVE_BASE, a[15:0]};
                    end
                    default: begin
                        o_result.target = brd_pkg::TGT_NONE;
                    end
                endcase
            end
            brd_pkg::PK_IO: begin
                o_result.piece_size = brd_pkg::SIZE_HALF;
                o_result.offset     = {18'd0, off};
                if (off < brd_pkg::OFF_VID_END) begin
                    o_result.target = brd_pkg::TGT_IO_VIDEO;
                end else if (off >= brd_pkg::OFF_DMA_LO && off < brd_pkg::OFF_DMA_END) begin
                    o_result.target = brd_pkg::TGT_IO_DMA;
                end else if (off >= brd_pkg::OFF_TMR_LO && off < brd_pkg::OFF_TMR_END) begin
                    o_result.target = brd_pkg::TGT_IO_TIMER;
                end else if (off >= brd_pkg::OFF_SND_LO && off < brd_pkg::OFF_DMA_LO) begin
                    o_result.target = brd_pkg::TGT_IO_SOUND;
                end else begin
                    o_result.target = brd_pkg::TGT_INTERNAL;
                    if (st) begin
                        o_reg_op.set_ie  = off == brd_pkg::OFF_IE;
                        o_reg_op.clr_if  = off == brd_pkg::OFF_IF;
                        o_reg_op.set_wc  = off == brd_pkg::OFF_WAITCNT;
                        o_reg_op.set_ime = off == brd_pkg::OFF_IME;
                        o_reg_op.mem_wr  = in_store;
                    end else begin
                        unique case (off)
                            brd_pkg::OFF_KEYS:    rv = {6'd0, brd_pkg::KEYS_IDLE & ~i_piece.keys};
                            brd_pkg::OFF_IE:      rv = i_irq_enable;
                            brd_pkg::OFF_IF:      rv = i_irq_flags;
                            brd_pkg::OFF_WAITCNT: rv = i_wait_control;
                            brd_pkg::OFF_IME:     rv = {15'd0, i_master_enable};
                            default:              o_reg_op.mem_rd = in_store;
                        endcase
                    end
                end
            end
            brd_pkg::PK_FIFO: begin
                o_result.target      = brd_pkg::TGT_FIFO_WORD;
                o_result.offset      = {18'd0, off};
                o_result.piece_size  = brd_pkg::SIZE_WORD;
                o_result.fifo_select = off[2];
            end
            brd_pkg::PK_RAISE: begin
                o_reg_op.raise_if = 1'b1;
            end
            default: begin
                o_result.target = brd_pkg::TGT_NONE;
            end
        endcase

        o_result.store_data = st ? i_piece.data : 32'd0;
        o_result.read_value = st ? 16'd0 : rv;
    end

endmodule

// ----- rtl/brd_regs.sv -----
// interrupt, wait and fallback io registers with the clearing pass
module brd_regs #(
    parameter int IO_HALFWORDS = 512
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  brd_pkg::t_reg_op i_op,
    output logic [15:0]      o_irq_enable,
    output logic [15:0]      o_irq_flags,
    output logic [15:0]      o_wait_control,
    output logic             o_master_enable,
    output logic [15:0]      o_store_data,
    output logic             o_busy
);

    localparam int AW = $clog2(IO_HALFWORDS);

    logic [15:0]   r_irq_enable;
    logic [15:0]   r_irq_flags;
    logic [15:0]   r_wait_control;
    logic          r_master_enable;
    logic          r_clearing;
    logic [AW-1:0] r_clr_idx;

    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [15:0]   ram_wr_data;

    always_comb begin
        if (r_clearing) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = r_clr_idx;
            ram_wr_data = '0;
        end else begin
            ram_wr_en   = i_en && i_op.mem_wr;
            ram_wr_addr = i_op.idx[AW-1:0];
            ram_wr_data = i_op.value;
        end
    end

    brd_ram #(
        .WIDTH (16),
        .DEPTH (IO_HALFWORDS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (i_en && i_op.mem_rd),
        .i_rd_addr (i_op.idx[AW-1:0]),
        .o_rd_data (o_store_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq_enable    <= '0;
            r_irq_flags     <= '0;
            r_wait_control  <= '0;
            r_master_enable <= 1'b0;
            r_clearing      <= 1'b1;
            r_clr_idx       <= '0;
        end else begin
            if (r_clearing) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == AW'(IO_HALFWORDS - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (i_en) begin
                if (i_op.set_ie) begin
                    r_irq_enable <= i_op.value;
                end
                if (i_op.clr_if) begin
                    r_irq_flags <= r_irq_flags & ~i_op.value;
                end else if (i_op.raise_if) begin
                    r_irq_flags <= r_irq_flags | i_op.value;
                end
                if (i_op.set_wc) begin
                    r_wait_control <= i_op.value;
                end
                if (i_op.set_ime) begin
                    r_master_enable <= i_op.value[0];
                end
            end
        end
    end

    assign o_irq_enable    = r_irq_enable;
    assign o_irq_flags     = r_irq_flags;
    assign o_wait_control  = r_wait_control;
    assign o_master_enable = r_master_enable;
    assign o_busy          = r_clearing;

endmodule

// ----- rtl/brd_checker.sv -----
// port level checks of the bus region decoder and their binding
`include "assert_macros.svh"

module brd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    `BRD_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled piece changed")

    `BRD_ASSERT(a_target_range, m_axis_tvalid |-> m_axis_tdata[3:0] != 4'd15, "target code out of range")

    `BRD_ASSERT(a_read_no_data, m_axis_tvalid && !m_axis_tdata[34] |-> m_axis_tdata[66:35] == 32'd0, "read piece carries store data")

    `BRD_ASSERT(a_store_no_value, m_axis_tvalid && m_axis_tdata[34] |-> m_axis_tdata[82:67] == 16'd0, "store piece carries read value")

    `BRD_ASSERT_ALWAYS(a_clear_after_reset, !i_rst_n |=> !s_axis_tready && !m_axis_tvalid, "item taken during store clearing")

endmodule

bind bus_region_decode_irq_regs brd_checker u_brd_checker (.*);

// ----- sim/bus_region_decode_irq_regs_tb.sv -----
// testbench for the bus region decoder: directed and random bus accesses checked piece by piece
`timescale 1ns / 1ps

module bus_region_decode_irq_regs_tb;

    localparam int          IO_HALFWORDS   = 512;
    localparam int          DIRECTED_ITEMS = 30;
    localparam int          RANDOM_ITEMS   = 220;
    localparam logic [1:0]  CMD_UNUSED     = 2'd3;
    localparam logic [1:0]  SIZE_WIDE      = 2'd3;
    localparam logic [31:0] IO_BASE        = 32'h04000000;
    localparam logic [27:0] SAVE_OFF_BASE  = 28'hE000000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  size;
        logic [31:0] addr;
        logic [31:0] wdata;
        logic [9:0]  buttons;
    } t_access;

    class piece_scoreboard;
        logic [15:0]      ie_q;
        logic [15:0]      if_q;
        logic [15:0]      waitcnt_q;
        logic             ime_q;
        logic [15:0]      keys_q;
        logic [15:0]      io_shadow [IO_HALFWORDS];
        brd_pkg::t_result pieces_due[$];
        brd_pkg::t_result batch[$];
        int               failures;
        int               pieces_seen;

        function new();
            ie_q        = '0;
            if_q        = '0;
            waitcnt_q   = '0;
            ime_q       = 1'b0;
            keys_q      = '0;
            failures    = 0;
            pieces_seen = 0;
            foreach (io_shadow[i]) io_shadow[i] = '0;
        endfunction

        function void add_piece(logic [3:0] tgt, logic [27:0] off, logic [1:0] sz, logic st,
                                logic [31:0] data, logic [15:0] rv, logic fsel);
            brd_pkg::t_result r;
            r.target      = tgt;
            r.offset      = off;
            r.piece_size  = sz;
            r.is_store    = st;
            r.store_data  = st ? data : 32'd0;
            r.read_value  = st ? 16'd0 : rv;
            r.fifo_select = fsel;
            r.last_piece  = 1'b0;
            batch.push_back(r);
        endfunction

        function void add_byte(logic [3:0] tgt, logic [27:0] off, logic st, logic [7:0] d);
            add_piece(tgt, off, brd_pkg::SIZE_BYTE, st, {24'd0, d}, 16'd0, 1'b0);
        endfunction

        function void add_half(logic [3:0] tgt, logic [9:0] off, logic st, logic [15:0] v,
                               logic [15:0] rv);
            add_piece(tgt, {18'd0, off}, brd_pkg::SIZE_HALF, st, {16'd0, v}, rv, 1'b0);
        endfunction

        function void byte_piece(logic st, logic [31:0] addr, logic [7:0] d);
            logic [27:0] a;
            logic [9:0]  io_off;
            logic [16:0] vid_off;
            a       = addr[27:0];
            io_off  = a[9:0];
            vid_off = a[16:0];
            if (vid_off >= brd_pkg::VRAM_MIRROR) begin
                vid_off = vid_off - brd_pkg::VRAM_FOLD;
            end
            case (a[27:24])
                brd_pkg::REG_WRAM_BIG: begin
                    add_byte(brd_pkg::TGT_WRAM_BIG, {10'd0, a[17:0]}, st, d);
                end
                brd_pkg::REG_WRAM_FAST: begin
                    add_byte(brd_pkg::TGT_WRAM_FAST, {13'd0, a[14:0]}, st, d);
                end
                brd_pkg::REG_IO: begin
                    if (st && io_off >= brd_pkg::OFF_SND_LO && io_off < brd_pkg::OFF_DMA_LO) begin
                        add_byte(brd_pkg::TGT_SND_BYTE, {18'd0, io_off}, st, d);
                    end else begin
                        add_byte(brd_pkg::TGT_NONE, 28'd0, st, d);
                    end
                end
                brd_pkg::REG_PALETTE: begin
                    add_byte(brd_pkg::TGT_PALETTE, {18'd0, io_off}, st, d);
                end
                brd_pkg::REG_VIDEO: begin
                    add_byte(brd_pkg::TGT_VIDEO, {11'd0, vid_off}, st, d);
                end
                brd_pkg::REG_SPRITE: begin
                    add_byte(brd_pkg::TGT_SPRITE, {18'd0, io_off}, st, d);
                end
                brd_pkg::REG_CART_0, brd_pkg::REG_CART_1, brd_pkg::REG_CART_2,
                brd_pkg::REG_CART_3, brd_pkg::REG_CART_4, brd_pkg::REG_CART_5: begin
                    if (st) begin
                        add_byte(brd_pkg::TGT_NONE, 28'd0, st, d);
                    end else begin
                        add_byte(brd_pkg::TGT_CART, a, st, d);
                    end
                end
                brd_pkg::REG_SAVE_0, brd_pkg::REG_SAVE_1: begin
                    add_byte(brd_pkg::TGT_SAVE, SAVE_OFF_BASE | {12'd0, a[15:0]}, st, d);
                end
                default: begin
                    add_byte(brd_pkg::TGT_NONE, 28'd0, st, d);
                end
            endcase
        endfunction

        function void io_piece(logic st, logic [31:0] addr, logic [15:0] v);
            logic [9:0]  off;
            logic [8:0]  idx;
            logic [15:0] rv;
            off = addr[9:0];
            idx = off[9:1];
            if (off < brd_pkg::OFF_VID_END) begin
                add_half(brd_pkg::TGT_IO_VIDEO, off, st, v, 16'd0);
            end else if (off >= brd_pkg::OFF_DMA_LO && off < brd_pkg::OFF_DMA_END) begin
                add_half(brd_pkg::TGT_IO_DMA, off, st, v, 16'd0);
            end else if (off >= brd_pkg::OFF_TMR_LO && off < brd_pkg::OFF_TMR_END) begin
                add_half(brd_pkg::TGT_IO_TIMER, off, st, v, 16'd0);
            end else if (off >= brd_pkg::OFF_SND_LO && off < brd_pkg::OFF_DMA_LO) begin
                add_half(brd_pkg::TGT_IO_SOUND, off, st, v, 16'd0);
            end else if (st) begin
                if (off == brd_pkg::OFF_IE) begin
                    ie_q = v;
                end else if (off == brd_pkg::OFF_IF) begin
                    if_q = if_q & ~v;
                end else if (off == brd_pkg::OFF_WAITCNT) begin
                    waitcnt_q = v;
                end else if (off == brd_pkg::OFF_IME) begin
                    ime_q = v[0];
                end
                if (int'(idx) < IO_HALFWORDS) begin
                    io_shadow[idx] = v;
                end
                add_half(brd_pkg::TGT_INTERNAL, off, 1'b1, v, 16'd0);
            end else begin
                if (off == brd_pkg::OFF_KEYS) begin
                    rv = keys_q;
                end else if (off == brd_pkg::OFF_IE) begin
                    rv = ie_q;
                end else if (off == brd_pkg::OFF_IF) begin
                    rv = if_q;
                end else if (off == brd_pkg::OFF_WAITCNT) begin
                    rv = waitcnt_q;
                end else if (off == brd_pkg::OFF_IME) begin
                    rv = {15'd0, ime_q};
                end else begin
                    rv = (int'(idx) < IO_HALFWORDS) ? io_shadow[idx] : 16'd0;
                end
                add_half(brd_pkg::TGT_INTERNAL, off, 1'b0, 16'd0, rv);
            end
        endfunction

        function void half_piece(logic st, logic [31:0] addr, logic [15:0] v);
            logic [31:0] a;
            a = {addr[31:1], 1'b0};
            if (a[31:10] == brd_pkg::IO_PAGE) begin
                io_piece(st, a, v);
            end else begin
                byte_piece(st, a, v[7:0]);
                byte_piece(st, a + 32'd1, v[15:8]);
            end
        endfunction

        function void note_access(t_access x);
            logic             st;
            logic [9:0]       off;
            brd_pkg::t_result tail;
            st     = (x.cmd == brd_pkg::CMD_WRITE);
            off    = x.addr[9:0];
            keys_q = {6'd0, brd_pkg::KEYS_IDLE & ~x.buttons};
            batch.delete();
            if (x.cmd == brd_pkg::CMD_RAISE) begin
                if_q = if_q | x.wdata[15:0];
            end else if (x.cmd == brd_pkg::CMD_READ || x.cmd == brd_pkg::CMD_WRITE) begin
                if (x.size == brd_pkg::SIZE_BYTE) begin
                    byte_piece(st, x.addr, x.wdata[7:0]);
                end else if (x.size == brd_pkg::SIZE_HALF) begin
                    half_piece(st, x.addr, x.wdata[15:0]);
                end else if (st && x.addr[1:0] == 2'b00 && x.addr[31:10] == brd_pkg::IO_PAGE
                             && off >= brd_pkg::OFF_FIFO_LO && off < brd_pkg::OFF_DMA_LO) begin
                    add_piece(brd_pkg::TGT_FIFO_WORD, {18'd0, off}, brd_pkg::SIZE_WORD, 1'b1,
                              x.wdata, 16'd0, off[2]);
                end else begin
                    half_piece(st, x.addr, x.wdata[15:0]);
                    half_piece(st, x.addr + 32'd2, x.wdata[31:16]);
                end
            end
            if (batch.size() > 0) begin
                tail = batch.pop_back();
                tail.last_piece = 1'b1;
                batch.push_back(tail);
            end
            foreach (batch[i]) pieces_due.push_back(batch[i]);
        endfunction

        function string piece_text(brd_pkg::t_result r);
            return $sformatf("tgt %0d off %h sz %0d st %0b data %h rv %h fifo %0b last %0b",
                             r.target, r.offset, r.piece_size, r.is_store, r.store_data,
                             r.read_value, r.fifo_select, r.last_piece);
        endfunction

        function void check_piece(brd_pkg::t_result got);
            brd_pkg::t_result want;
            string            bad;
            pieces_seen++;
            if (pieces_due.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("unexpected piece: %s", piece_text(got));
                end
                return;
            end
            want = pieces_due.pop_front();
            bad  = "";
            if (got.target !== want.target) bad = {bad, " target"};
            if (got.offset !== want.offset) bad = {bad, " offset"};
            if (got.piece_size !== want.piece_size) bad = {bad, " piece_size"};
            if (got.is_store !== want.is_store) bad = {bad, " is_store"};
            if (got.store_data !== want.store_data) bad = {bad, " store_data"};
            if (got.read_value !== want.read_value) bad = {bad, " read_value"};
            if (got.fifo_select !== want.fifo_select) bad = {bad, " fifo_select"};
            if (got.last_piece !== want.last_piece) bad = {bad, " last_piece"};
            if (bad != "") begin
                failures++;
                if (failures <= 10) begin
                    $display("piece %0d mismatch in%s", pieces_seen, bad);
                    $display("  expected %s", piece_text(want));
                    $display("  actual   %s", piece_text(got));
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // command, access_size, address, write_data, buttons, zero fill
    logic [79:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // target, offset, piece_size, is_store, store_data, read_value, fifo_select, zero fill
    logic [87:0] m_axis_tdata;
    logic        m_axis_tlast;

    piece_scoreboard board = new();
    int              items_sent = 0;
    bit              src_steady = 1'b0;

    bus_region_decode_irq_regs #(
        .IO_HALFWORDS(IO_HALFWORDS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int pick_gap(bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [31:0] io_addr(logic [9:0] off);
        return {IO_BASE[31:10], off};
    endfunction

    function automatic logic [9:0] pick_io_offset();
        case ($urandom_range(0, 9))
            0: return brd_pkg::OFF_KEYS;
            1: return brd_pkg::OFF_IE;
            2: return brd_pkg::OFF_IF;
            3: return brd_pkg::OFF_WAITCNT;
            4: return brd_pkg::OFF_IME;
            5: return 10'($urandom_range(brd_pkg::OFF_FIFO_LO, brd_pkg::OFF_DMA_LO - 1));
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic logic [31:0] rand_address();
        logic [31:0] a;
        int          r;
        r = $urandom_range(0, 99);
        a = $urandom;
        if (r < 40) begin
            a = io_addr(pick_io_offset());
        end else if (r < 45) begin
            a[31:24] = 8'h04;
        end else if (r < 88) begin
            if ($urandom_range(0, 9) != 0) a[31:28] = 4'h0;
        end
        return a;
    endfunction

    task automatic send_access(input logic [1:0] cmd, input logic [1:0] size,
                               input logic [31:0] addr, input logic [31:0] wdata,
                               input logic [9:0] buttons);
        t_access x;
        int      gap;
        x   = '{cmd, size, addr, wdata, buttons};
        gap = pick_gap(src_steady);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, buttons, wdata, addr, size, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_access(x);
        if (cmd != CMD_UNUSED) items_sent++;
    endtask

    initial begin : piece_sink
        brd_pkg::t_result got;
        int               stall_left;
        int               cycle_n;
        bit               held_once;
        bit               sink_steady;
        stall_left    = 0;
        cycle_n       = 0;
        held_once     = 1'b0;
        sink_steady   = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got.target      = m_axis_tdata[3:0];
                got.offset      = m_axis_tdata[31:4];
                got.piece_size  = m_axis_tdata[33:32];
                got.is_store    = m_axis_tdata[34];
                got.store_data  = m_axis_tdata[66:35];
                got.read_value  = m_axis_tdata[82:67];
                got.fifo_select = m_axis_tdata[83];
                got.last_piece  = m_axis_tlast;
                board.check_piece(got);
            end
            cycle_n++;
            if (cycle_n % 128 == 0) sink_steady = ($urandom_range(0, 3) == 0);
            // one long hold while the source keeps pushing, so the pipe backs up
            if (!held_once && board.pieces_seen >= 150) begin
                held_once  = 1'b1;
                stall_left = 400;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                stall_left = pick_gap(sink_steady);
            end
        end
    end

    initial begin : access_source
        int          r;
        int          rounds;
        logic [31:0] a;
        logic [9:0]  off;
        logic [1:0]  cmd;
        logic [1:0]  size;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // memory regions, mirrors and ignored areas
        send_access(brd_pkg::CMD_READ,  brd_pkg::SIZE_BYTE, 32'h00000000, 32'h0, 10'h000);
        send_access(brd_pkg::CMD_WRITE, brd_pkg::SIZE_BYTE, 32'h02FFFFFF, 32'hFFFFFFFF, 10'h3FF);
        send_access(brd_pkg::CMD_READ,  brd_pkg::SIZE_BYTE, 32'h03007FFF, 32'h0, 10'h155);
        send_access(brd_pkg::CMD_READ,  brd_pkg::SIZE_HALF, 32'h05000001, 32'h0, 10'h2AA);
        send_access(brd_pkg::CMD_WRITE, brd_pkg::SIZE_HALF, 32'h06018001, 32'hA5A5C3C3, 10'h000);
        send_access(brd_pkg::CMD_READ,  brd_pkg::SIZE_WORD, 32'h0601FFFE, 32'h0, 10'h000);
        send_access(brd_pkg::CMD_READ,  brd_pkg::SIZE_BYTE, 32'h070003FF, 32'h0, 10'h000);
        send_access(brd_pkg::CMD_READ,  brd_pkg::SIZE_BYTE, 32'h08000123, 32'h0, 10'h000);
        send_access(brd_pkg::CMD_WRITE, brd_pkg::SIZE_BYTE, 32'h0DFFFFFF, 32'h000000FF, 10'h000);
        send_access(brd_pkg::CMD_WRITE, brd_pkg::SIZE_WORD, 32'h0E00FFFC, 32'h12345678, 10'h000);
        send_access(brd_pkg::CMD_READ,  brd_pkg::SIZE_BYTE, 32'h01000000, 32'h0, 10'h000);
        send_access(brd_pkg::CMD_READ,  brd_pkg::SIZE_HALF, 32'hF0000000, 32'h0, 10'h000);
        // interrupt and wait registers, raise and write-one-to-clear
        send_access(brd_pkg::CMD_WRITE, brd_pkg::SIZE_HALF, io_addr(brd_pkg::OFF_IE),
                    32'h0000FFFF, 10'h000);
        send_access(brd_pkg::CMD_WRITE, brd_pkg::SIZE_HALF, io_addr(brd_pkg::OFF_IME),
                    32'hFFFF0001, 10'h000);
        send_access(brd_pkg::CMD_WRITE, brd_pkg::SIZE_HALF, io_addr(brd_pkg::OFF_WAITCNT),
                    32'h0000ABCD, 10'h000);
        send_access(brd_pkg::CMD_RAISE, brd_pkg::SIZE_WORD, 32'hFFFFFFFF, 32'hFFFFFFFF, 10'h000);
        send_access(brd_pkg::CMD_WRITE, brd_pkg::SIZE_HALF, io_addr(brd_pkg::OFF_IF),
                    32'h000000FF, 10'h000);
        send_access(brd_pkg::CMD_READ,  brd_pkg::SIZE_WORD, io_addr(brd_pkg::OFF_IE),
                    32'h0, 10'h000);
        send_access(brd_pkg::CMD_READ,  brd_pkg::SIZE_HALF, io_addr(brd_pkg::OFF_KEYS),
                    32'h0, 10'h3FF);
        send_access(brd_pkg::CMD_READ,  brd_pkg::SIZE_HALF, io_addr(brd_pkg::OFF_KEYS),
                    32'h0, 10'h000);
        // sound fifo words, sound bytes and the io units
        send_access(brd_pkg::CMD_WRITE, brd_pkg::SIZE_WORD, io_addr(brd_pkg::OFF_FIFO_LO),
                    32'hDEADBEEF, 10'h000);
        send_access(brd_pkg::CMD_WRITE, brd_pkg::SIZE_WORD, io_addr(10'h0A6),
                    32'h01020304, 10'h000);
        send_access(brd_pkg::CMD_WRITE, brd_pkg::SIZE_BYTE, io_addr(brd_pkg::OFF_SND_LO),
                    32'h0000005A, 10'h000);
        send_access(brd_pkg::CMD_WRITE, brd_pkg::SIZE_BYTE, io_addr(brd_pkg::OFF_DMA_LO),
                    32'h0000005A, 10'h000);
        send_access(brd_pkg::CMD_READ,  brd_pkg::SIZE_WORD, io_addr(10'h10E), 32'h0, 10'h000);
        // page edge, upper address bits, wrap-around and unused codes
        send_access(brd_pkg::CMD_READ,  brd_pkg::SIZE_WORD, io_addr(10'h3FE), 32'h0, 10'h000);
        send_access(brd_pkg::CMD_WRITE, brd_pkg::SIZE_HALF, 32'h14000200, 32'h0000FFFF, 10'h000);
        send_access(brd_pkg::CMD_READ,  SIZE_WIDE, 32'hFFFFFFFE, 32'h0, 10'h000);
        send_access(CMD_UNUSED, SIZE_WIDE, io_addr(brd_pkg::OFF_IE), 32'hFFFFFFFF, 10'h3FF);
        send_access(brd_pkg::CMD_WRITE, brd_pkg::SIZE_HALF, io_addr(10'h300),
                    32'h00001234, 10'h000);
        send_access(brd_pkg::CMD_READ,  brd_pkg::SIZE_HALF, io_addr(10'h301), 32'h0, 10'h000);

        rounds = 0;
        while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            rounds++;
            if (rounds % 25 == 0) src_steady = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 60) begin
                r   = $urandom_range(0, 99);
                cmd = (r < 45) ? brd_pkg::CMD_READ : (r < 88) ? brd_pkg::CMD_WRITE :
                      (r < 95) ? brd_pkg::CMD_RAISE : CMD_UNUSED;
                send_access(cmd, 2'($urandom_range(0, 3)), rand_address(), $urandom,
                            10'($urandom_range(0, 1023)));
            end else if (r < 82) begin
                off = pick_io_offset();
                a   = io_addr(off);
                send_access(brd_pkg::CMD_WRITE, brd_pkg::SIZE_HALF, a, $urandom,
                            10'($urandom_range(0, 1023)));
                if ($urandom_range(0, 2) == 0) begin
                    send_access(brd_pkg::CMD_RAISE, brd_pkg::SIZE_WORD, $urandom, $urandom,
                                10'($urandom_range(0, 1023)));
                end
                size = ($urandom_range(0, 1) == 0) ? brd_pkg::SIZE_HALF : brd_pkg::SIZE_WORD;
                send_access(brd_pkg::CMD_READ, size, a, $urandom,
                            10'($urandom_range(0, 1023)));
            end else if (r < 92) begin
                off = brd_pkg::OFF_FIFO_LO + {6'd0, 2'($urandom_range(0, 3)), 2'b00};
                if ($urandom_range(0, 3) == 0) off[1:0] = 2'($urandom_range(1, 3));
                send_access(brd_pkg::CMD_WRITE, brd_pkg::SIZE_WORD, io_addr(off), $urandom,
                            10'($urandom_range(0, 1023)));
            end else begin
                send_access(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), $urandom,
                            $urandom, 10'($urandom_range(0, 1023)));
            end
        end

        s_axis_tvalid <= 1'b0;
        while (board.pieces_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("run covered %0d accesses across all regions, io registers and fifos",
                 items_sent);
        $display("%0d pieces checked, %0d mismatches", board.pieces_seen, board.failures);
        if (board.failures == 0 && board.pieces_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : watchdog
        #3000000;
        $display("watchdog expired with %0d pieces outstanding", board.pieces_due.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- bus_region_decode_irq_regs.f -----
+incdir+rtl
rtl/brd_pkg.sv
rtl/brd_ram.sv
rtl/brd_piece_gen.sv
rtl/brd_decode.sv
rtl/brd_regs.sv
rtl/bus_region_decode_irq_regs.sv
rtl/brd_checker.sv
sim/bus_region_decode_irq_regs_tb.sv
